[hdl/smpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_pkg: shared types for the sorted minimum priority queue
// Command and status codes, beat payload structs and the key compare.
// ----------------------------------------------------------------------------
package smpq_pkg;

  localparam int unsigned KeyWidth  = 32;
  localparam int unsigned FillWidth = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PLACE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                        cmd;
    logic signed [KeyWidth-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [KeyWidth-1:0]  popped_value;
    status_t                     status;
    logic        [FillWidth-1:0] fill_count;
  } rsp_t;

  function automatic logic key_less(input logic signed [KeyWidth-1:0] a,
                                    input logic signed [KeyWidth-1:0] b);
    return a < b;
  endfunction

endpackage

[hdl/sorted_min_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue: ascending priority queue on a sorted list
//
// A request beat on req carries a command (insert value or remove minimum)
// and a signed 32-bit key. Every request gives exactly one response beat on
// rsp with the popped key, a status code and the fill count after the
// command. An insert into a full queue is dropped (overflow); a remove from
// an empty queue returns 0 with underflow status.
// Keys live in a ring buffer in one single-port-write memory; an insert
// walks from the tail toward the head through one comparator, one memory
// read and one write per cycle. A remove goes via S_POP to S_FIN; an insert
// shifts each held key not smaller than the new one up in S_SCAN, writes
// the new key there or in S_PLACE; an overflow or underflow goes to S_FIN.
// One command is in flight at a time; req_ready rises again once the
// response is loaded into the output register, so a new request may enter
// while that response still waits for rsp_ready.
// Reset empties the queue; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  smpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output smpq_pkg::rsp_t rsp
);
  import smpq_pkg::*;

  logic res_valid;
  logic res_ready;
  rsp_t res;

  smpq_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> !res_valid)
    else $error("request accepted while a result is pending");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_UNDERFLOW) |->
      (res.fill_count == '0 && res.popped_value == '0))
    else $error("underflow result not zero");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_OVERFLOW) |->
      (res.fill_count == FillWidth'(QUEUE_DEPTH)))
    else $error("overflow reported on a queue that is not full");

  a_pop_only_remove: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_REMOVED) |-> (res.popped_value == '0))
    else $error("nonzero key on a result that popped nothing");

endmodule

[hdl/smpq_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_seq: queue store and command sequencer
// Ring buffer of sorted keys; insert walks down from the tail through one
// compare unit, one memory read port and one write port; remove pops at the head.
// ----------------------------------------------------------------------------
module smpq_seq #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  smpq_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output smpq_pkg::rsp_t res
);
  import smpq_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic signed [KeyWidth-1:0] mem [QUEUE_DEPTH];
  logic signed [KeyWidth-1:0] rdata;

  logic                       mem_we;
  logic        [AW-1:0]       mem_waddr;
  logic signed [KeyWidth-1:0] mem_wdata;
  logic                       mem_re;
  logic        [AW-1:0]       mem_raddr;

  state_t                     state, state_next;
  logic        [CW-1:0]       count, count_next;
  logic        [CW-1:0]       left, left_next;
  logic        [AW-1:0]       head, head_next;
  logic        [AW-1:0]       tail, tail_next;
  logic        [AW-1:0]       hole, hole_next;
  logic        [AW-1:0]       rd_ptr, rd_ptr_next;
  logic signed [KeyWidth-1:0] key, key_next;
  rsp_t                       res_q, res_next;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    if (p == '0) begin
      return AW'(QUEUE_DEPTH - 1);
    end
    return p - AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    left   <= left_next;
    hole   <= hole_next;
    rd_ptr <= rd_ptr_next;
    key    <= key_next;
    res_q  <= res_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    left_next   = left;
    head_next   = head;
    tail_next   = tail;
    hole_next   = hole;
    rd_ptr_next = rd_ptr;
    key_next    = key;
    res_next    = res_q;
    mem_we      = 1'b0;
    mem_waddr   = hole;
    mem_wdata   = key;
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr;
    req_ready   = (state == S_IDLE);
    res_valid   = (state == S_FIN);

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          key_next              = req.value;
          res_next.popped_value = '0;
          if (req.cmd == CMD_INSERT) begin
            if (count == CW'(QUEUE_DEPTH)) begin
              res_next.status     = ST_OVERFLOW;
              res_next.fill_count = FillWidth'(count);
              state_next          = S_FIN;
            end else begin
              res_next.status     = ST_INSERTED;
              res_next.fill_count = FillWidth'(count + CW'(1));
              count_next          = count + CW'(1);
              tail_next           = ptr_inc(tail);
              hole_next           = tail;
              left_next           = count;
              if (count == '0) begin
                state_next = S_PLACE;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = ptr_dec(tail);
                rd_ptr_next = ptr_dec(tail);
                state_next  = S_SCAN;
              end
            end
          end else begin
            if (count == '0) begin
              res_next.status     = ST_UNDERFLOW;
              res_next.fill_count = '0;
              state_next          = S_FIN;
            end else begin
              mem_re              = 1'b1;
              mem_raddr           = head;
              head_next           = ptr_inc(head);
              count_next          = count - CW'(1);
              res_next.status     = ST_REMOVED;
              res_next.fill_count = FillWidth'(count - CW'(1));
              state_next          = S_POP;
            end
          end
        end
      end
      S_POP: begin
        res_next.popped_value = rdata;
        state_next            = S_FIN;
      end
      S_SCAN: begin
        if (key_less(rdata, key)) begin
          mem_we     = 1'b1;
          state_next = S_FIN;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = rdata;
          hole_next = rd_ptr;
          left_next = left - CW'(1);
          if (left == CW'(1)) begin
            state_next = S_PLACE;
          end else begin
            mem_re      = 1'b1;
            mem_raddr   = ptr_dec(rd_ptr);
            rd_ptr_next = ptr_dec(rd_ptr);
          end
        end
      end
      S_PLACE: begin
        mem_we     = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res = res_q;

endmodule

[sim/smpq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_checker: response checker for the sorted minimum priority queue
// Watches the req and rsp channels, keeps its own sorted copy of the held
// keys, predicts one response per accepted command and compares each
// response beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module smpq_checker #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  smpq_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  smpq_pkg::rsp_t rsp,
  output int             fail_count,
  output int             outstanding
);

  import smpq_pkg::*;

  logic signed [KeyWidth-1:0] sorted_keys[$];
  rsp_t                       pending_results[$];
  rsp_t                       want;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  function automatic rsp_t predict_result(input req_t beat);
    rsp_t                       res;
    logic signed [KeyWidth-1:0] key;
    int                         pos;
    key              = beat.value;
    res.popped_value = '0;
    if (beat.cmd == CMD_INSERT) begin
      if (sorted_keys.size() >= QUEUE_DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < sorted_keys.size() && sorted_keys[pos] < key) pos++;
        sorted_keys.insert(pos, key);
        res.status = ST_INSERTED;
      end
    end else begin
      if (sorted_keys.size() == 0) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.popped_value = sorted_keys.pop_front();
        res.status       = ST_REMOVED;
      end
    end
    res.fill_count = FillWidth'(sorted_keys.size());
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sorted_keys.delete();
      pending_results.delete();
      outstanding <= 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          $error("rsp beat with no command waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.popped_value !== want.popped_value) begin
            $error("popped_value: expected %0d, got %0d", want.popped_value,
                   rsp.popped_value);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.fill_count !== want.fill_count) begin
            $error("fill_count: expected %0d, got %0d", want.fill_count,
                   rsp.fill_count);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) pending_results.push_back(predict_result(req));
      outstanding <= pending_results.size();
    end
  end

endmodule

[sim/sorted_min_priority_queue_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_tb: stimulus and verdict for the priority queue
// Drives a short directed sequence (underflow, key extremes, equal keys,
// drain) and then bursts of random commands whose insert share swings from
// high to low, so the queue fills to overflow and drains to underflow again.
// Both channels idle at random; the checker counts every mismatch.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_tb;

  import smpq_pkg::*;

  localparam int unsigned              Depth       = 16;
  localparam int                       RandomBeats = 1900;
  localparam logic signed [KeyWidth-1:0] KeyMin    = 32'sh8000_0000;
  localparam logic signed [KeyWidth-1:0] KeyMax    = 32'sh7FFF_FFFF;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  logic quiet     = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;
  int   fail_count;
  int   outstanding;
  int   ready_hold  = 0;
  int   stall;

  always #10 clk = ~clk;

  sorted_min_priority_queue #(
    .QUEUE_DEPTH(Depth)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  smpq_checker #(
    .QUEUE_DEPTH(Depth)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [KeyWidth-1:0] pick_key();
    int unsigned                r;
    logic signed [KeyWidth-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      k = $urandom;
    end else if (r < 80) begin
      k = $urandom_range(0, 8);
      k = k - 32'sd4;
    end else begin
      case ($urandom_range(0, 3))
        0:       k = KeyMin;
        1:       k = KeyMax;
        2:       k = '0;
        default: k = -32'sd1;
      endcase
    end
    return k;
  endfunction

  task automatic send_beat(input cmd_t c, input logic signed [KeyWidth-1:0] v,
                           input int gap);
    req_valid <= 1'b1;
    req       <= '{cmd: c, value: v};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold rsp_ready high for a while, then drop it for a random stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (quiet || !rsp_ready) begin
      rsp_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      stall = pick_gap();
      if (stall != 0) begin
        rsp_ready  <= 1'b0;
        ready_hold <= stall - 1;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int   beats_sent;
    int   burst_len;
    int   insert_pct;
    logic calm;
    cmd_t c;
    beats_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(CMD_REMOVE, 32'sh1234_5678, pick_gap());
    send_beat(CMD_INSERT, 32'sd0, pick_gap());
    send_beat(CMD_INSERT, KeyMax, pick_gap());
    send_beat(CMD_INSERT, KeyMin, pick_gap());
    send_beat(CMD_INSERT, -32'sd1, pick_gap());
    send_beat(CMD_INSERT, 32'sd1, pick_gap());
    send_beat(CMD_INSERT, 32'sd0, pick_gap());
    send_beat(CMD_INSERT, KeyMax, pick_gap());
    send_beat(CMD_INSERT, KeyMin, pick_gap());
    repeat (5) send_beat(CMD_REMOVE, -32'sd1, pick_gap());
    send_beat(CMD_INSERT, 32'sh5555_5555, pick_gap());
    send_beat(CMD_INSERT, 32'shAAAA_AAAA, pick_gap());
    repeat (6) send_beat(CMD_REMOVE, KeyMin, pick_gap());

    while (beats_sent < RandomBeats) begin
      burst_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      calm  = ($urandom_range(0, 3) == 0);
      quiet <= calm;
      repeat (burst_len) begin
        c = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_REMOVE;
        send_beat(c, pick_key(), calm ? 0 : pick_gap());
        beats_sent++;
      end
    end
    if (req_valid) req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
